[hdl/misbehaviour_report_table_macros.svh]
// Assertion macros shared by the misbehaviour report table modules.
`ifndef MISBEHAVIOUR_REPORT_TABLE_MACROS_SVH
`define MISBEHAVIOUR_REPORT_TABLE_MACROS_SVH
`ifndef SYNTH
// Concurrent check on an explicit clock and active-low reset.
`define MRT_ASSERT_AT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// Concurrent check on the block clock and reset.
`define MRT_ASSERT(name, prop) `MRT_ASSERT_AT(name, clk_i, rst_ni, prop)
`else
`define MRT_ASSERT_AT(name, clk, rstn, prop)
`define MRT_ASSERT(name, prop)
`endif
`endif

[hdl/mrt_pkg.sv]
// Types, codes and microcode program of the misbehaviour report table.
package mrt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned ID_W   = 64;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned S_DATA_W = 96;  // suspect_id, now_ticks
  localparam int unsigned M_DATA_W = 72;  // reported_id, is_new, has_entry, pad
  localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(1000);

  // Register indexes
  localparam logic REG_COLLECTION_PERIOD = 1'b0;
  localparam logic REG_GRACE_PERIOD      = 1'b1;

  // Operation and result kind codes
  localparam logic OP_REPORT    = 1'b0;
  localparam logic OP_COLLECT   = 1'b1;
  localparam logic KIND_ANSWER  = 1'b0;
  localparam logic KIND_COLLECT = 1'b1;

  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE     = 3'd0;
  localparam step_t ST_DISPATCH = 3'd1;
  localparam step_t ST_R_ADDR   = 3'd2;
  localparam step_t ST_R_CMP    = 3'd3;
  localparam step_t ST_R_ANS    = 3'd4;
  localparam step_t ST_C_ADDR   = 3'd5;
  localparam step_t ST_C_EVAL   = 3'd6;
  localparam step_t ST_C_END    = 3'd7;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_COLLECT,
    C_SCAN_DONE,
    C_NO_MATCH
  } cond_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_LATCH,
    A_MATCH,
    A_ANSWER,
    A_EVAL,
    A_FINISH
  } act_e;

  typedef struct packed {
    cond_e cond;
    step_t target;
    act_e  act;
  } ucode_t;

  typedef struct packed {
    logic collect;
    logic scan_done;
    logic match;
    logic hold;
  } status_t;

  // Control store: jump to target when cond holds, else fall through.
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    unique case (step)
      ST_IDLE:     w = '{cond: C_NO_INPUT,  target: ST_IDLE,   act: A_LATCH};
      ST_DISPATCH: w = '{cond: C_COLLECT,   target: ST_C_ADDR, act: A_NONE};
      ST_R_ADDR:   w = '{cond: C_SCAN_DONE, target: ST_R_ANS,  act: A_NONE};
      ST_R_CMP:    w = '{cond: C_NO_MATCH,  target: ST_R_ADDR, act: A_MATCH};
      ST_R_ANS:    w = '{cond: C_ALWAYS,    target: ST_IDLE,   act: A_ANSWER};
      ST_C_ADDR:   w = '{cond: C_SCAN_DONE, target: ST_C_END,  act: A_NONE};
      ST_C_EVAL:   w = '{cond: C_ALWAYS,    target: ST_C_ADDR, act: A_EVAL};
      ST_C_END:    w = '{cond: C_ALWAYS,    target: ST_IDLE,   act: A_FINISH};
      default:     w = '{cond: C_ALWAYS,    target: ST_IDLE,   act: A_NONE};
    endcase
    return w;
  endfunction

endpackage

[hdl/misbehaviour_report_table.sv]
// Misbehaviour report table: top level with the microcode sequencer.
// A report reads and compares the stored entries in order until the identifier matches
// or all n stored entries are checked; a collect evaluates every one of the n stored
// entries. The microcode spends one step issuing a table read and one step evaluating
// it for each entry, since the table memory has a registered read. The sequencer stalls
// only while the result register waits for the downstream side. The input is taken only
// in the idle step; a finished result may still be waiting in the output register when
// the next item enters.
// The table holds up to TABLE_DEPTH entries and needs no clearing pass after reset.
module misbehaviour_report_table #(
  parameter int unsigned TABLE_DEPTH = mrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [mrt_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mrt_pkg::S_DATA_W-1:0]  s_axis_tdata,  // suspect_id, now_ticks
  input  logic [0:0]                    s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mrt_pkg::M_DATA_W-1:0]  m_axis_tdata,  // reported_id, is_new, has_entry
  output logic [0:0]                    m_axis_tuser,  // result_kind
  output logic                          m_axis_tlast
);
  import mrt_pkg::*;

  step_t   pc_q, pc_d;
  ucode_t  uw;
  status_t st;
  logic    taken;
  logic    out_kind, out_new, out_has;
  logic [ID_W-1:0] out_id;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_NO_INPUT:  taken = !s_axis_tvalid;
      C_COLLECT:   taken = st.collect;
      C_SCAN_DONE: taken = st.scan_done;
      C_NO_MATCH:  taken = !st.match;
      default:     taken = 1'b0;
    endcase
  end

  // Hold the step while a result is due but the result register is busy
  always_comb begin
    if (st.hold) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign s_axis_tready = (pc_q == ST_IDLE);

  mrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .act_i       (uw.act),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser[0]),
    .in_id_i     (s_axis_tdata[ID_W-1:0]),
    .in_now_i    (s_axis_tdata[ID_W +: TICK_W]),
    .status_o    (st),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_id_o    (out_id),
    .out_new_o   (out_new),
    .out_has_o   (out_has),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(M_DATA_W - ID_W - 2)'(0), out_has, out_new, out_id};
  assign m_axis_tuser = out_kind;

`include "misbehaviour_report_table_macros.svh"

  `MRT_ASSERT(a_accept_dispatches, (s_axis_tvalid && s_axis_tready) |=> pc_q == ST_DISPATCH)
  `MRT_ASSERT(a_hold_keeps_step, st.hold |=> pc_q == $past(pc_q))
  `MRT_ASSERT(a_busy_not_ready, (pc_q != ST_IDLE) |-> !s_axis_tready)

endmodule

[hdl/mrt_datapath.sv]
// Table memories, scan counters, config registers and result register.
module mrt_datapath #(
  parameter int unsigned TABLE_DEPTH = mrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [mrt_pkg::CFG_W-1:0] cfg_wdata_i,
  input  mrt_pkg::act_e             act_i,
  input  logic                      in_valid_i,
  input  logic                      in_op_i,
  input  logic [mrt_pkg::ID_W-1:0]  in_id_i,
  input  logic [mrt_pkg::TICK_W-1:0] in_now_i,
  output mrt_pkg::status_t          status_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_kind_o,
  output logic [mrt_pkg::ID_W-1:0]  out_id_o,
  output logic                      out_new_o,
  output logic                      out_has_o,
  output logic                      out_last_o
);
  import mrt_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [ID_W-1:0]   id_mem [TABLE_DEPTH];
  logic [TICK_W-1:0] rs_mem [TABLE_DEPTH];
  logic [TICK_W-1:0] ms_mem [TABLE_DEPTH];

  logic [CFG_W-1:0]  cp_q, gp_q;
  logic              op_q;
  logic [ID_W-1:0]   sid_q;
  logic [TICK_W-1:0] now_q;
  logic [CW-1:0]     count_q, idx_q, keep_q;
  logic              hit_q, pend_valid_q;
  logic [ID_W-1:0]   pend_id_q;
  logic [ID_W-1:0]   rd_id_q;
  logic [TICK_W-1:0] rd_rs_q, rd_ms_q;
  logic              out_valid_q, out_kind_q, out_new_q, out_has_q, out_last_q;
  logic [ID_W-1:0]   out_id_q;

  logic              match, due, drop, out_free, hold, go;
  logic [TICK_W-1:0] report_age, misbehave_age;
  logic [TICK_W:0]   drop_limit;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [ID_W-1:0]   wr_id;
  logic [TICK_W-1:0] wr_rs, wr_ms;
  logic              emit, e_kind, e_new, e_has, e_last;
  logic [ID_W-1:0]   e_id;

  assign match         = (rd_id_q == sid_q);
  assign report_age    = now_q - rd_rs_q;
  assign misbehave_age = now_q - rd_ms_q;
  assign due           = report_age > cp_q;
  assign drop_limit    = {1'b0, cp_q} + {1'b0, gp_q};
  assign drop          = {1'b0, misbehave_age} > drop_limit;
  assign out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (act_i)
      A_ANSWER, A_FINISH: hold = !out_free;
      A_EVAL:             hold = due && pend_valid_q && !out_free;
      default:            hold = 1'b0;
    endcase
  end
  assign go = !hold;

  assign status_o = '{collect: (op_q == OP_COLLECT), scan_done: (idx_q == count_q),
                      match: match, hold: hold};

  // Memory write port and result selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_id   = rd_id_q;
    wr_rs   = rd_rs_q;
    wr_ms   = rd_ms_q;
    emit    = 1'b0;
    e_kind  = KIND_ANSWER;
    e_id    = '0;
    e_new   = 1'b0;
    e_has   = 1'b0;
    e_last  = 1'b0;
    unique case (act_i)
      A_MATCH: begin
        wr_en = match;
        wr_ms = now_q;
      end
      A_ANSWER: begin
        wr_en   = go && !hit_q && (count_q < DEPTH_C);
        wr_addr = count_q[IW-1:0];
        wr_id   = sid_q;
        wr_rs   = now_q;
        wr_ms   = now_q;
        emit    = go;
        e_new   = !hit_q;
        e_last  = 1'b1;
      end
      A_EVAL: begin
        wr_en   = go && !drop;
        wr_addr = keep_q[IW-1:0];
        wr_rs   = due ? now_q : rd_rs_q;
        emit    = go && due && pend_valid_q;
        e_kind  = KIND_COLLECT;
        e_id    = pend_id_q;
        e_has   = 1'b1;
      end
      A_FINISH: begin
        emit   = go;
        e_kind = KIND_COLLECT;
        e_id   = pend_valid_q ? pend_id_q : '0;
        e_has  = pend_valid_q;
        e_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_id;
      rs_mem[wr_addr] <= wr_rs;
      ms_mem[wr_addr] <= wr_ms;
    end
    rd_id_q <= id_mem[idx_q[IW-1:0]];
    rd_rs_q <= rs_mem[idx_q[IW-1:0]];
    rd_ms_q <= ms_mem[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q         <= PERIOD_RESET;
      gp_q         <= PERIOD_RESET;
      op_q         <= OP_REPORT;
      count_q      <= '0;
      idx_q        <= '0;
      keep_q       <= '0;
      hit_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_COLLECTION_PERIOD: cp_q <= cfg_wdata_i;
          REG_GRACE_PERIOD:      gp_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (act_i)
        A_LATCH: begin
          if (in_valid_i) begin
            op_q         <= in_op_i;
            idx_q        <= '0;
            keep_q       <= '0;
            hit_q        <= 1'b0;
            pend_valid_q <= 1'b0;
          end
        end
        A_MATCH: begin
          idx_q <= idx_q + CW'(1);
          if (match) hit_q <= 1'b1;
        end
        A_ANSWER: begin
          if (go && !hit_q && (count_q < DEPTH_C)) count_q <= count_q + CW'(1);
        end
        A_EVAL: begin
          if (go) begin
            idx_q <= idx_q + CW'(1);
            if (!drop) keep_q <= keep_q + CW'(1);
            if (due) pend_valid_q <= 1'b1;
          end
        end
        A_FINISH: begin
          if (go) count_q <= keep_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (act_i == A_LATCH && in_valid_i) begin
      sid_q <= in_id_i;
      now_q <= in_now_i;
    end
    if (act_i == A_EVAL && go && due) pend_id_q <= rd_id_q;
    if (emit) begin
      out_kind_q <= e_kind;
      out_id_q   <= e_id;
      out_new_q  <= e_new;
      out_has_q  <= e_has;
      out_last_q <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_new_o   = out_new_q;
  assign out_has_o   = out_has_q;
  assign out_last_o  = out_last_q;

`include "misbehaviour_report_table_macros.svh"

  `MRT_ASSERT(a_count_bounded, count_q <= DEPTH_C)
  `MRT_ASSERT(a_keep_behind_scan, keep_q <= idx_q)
  `MRT_ASSERT(a_hold_blocks_write, hold |-> !wr_en && !emit)
  `MRT_ASSERT(a_finish_sets_count, (act_i == A_FINISH && go) |=> count_q == $past(keep_q))

endmodule
